@@ design/ddr_pkg.sv @@
// Package for the double divide unit: widths, constants and the stage record.
// No dependencies.
package ddr_pkg;
  localparam int DataW  = 64;
  localparam int ManW   = 53;
  localparam int QuotW  = 54;
  localparam int ExpW   = 13;
  localparam int NumSt  = 6;
  localparam int BitsSt = QuotW / NumSt;
  localparam logic [10:0] ExpMax = 11'h7ff;
  localparam logic [ExpW-1:0] Rebias = 13'h3fe;

  typedef struct packed {
    logic        sign;
    logic        zden;
    logic        znum;
    logic signed [ExpW-1:0] exp;
    logic [ManW:0] num;
    logic [ManW-1:0] den;
    logic [QuotW-1:0] quo;
  } ddr_st_t;
endpackage

@@ design/ddr_if.sv @@
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
interface ddr_if #(parameter int W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ design/ddr_prep.sv @@
// Operand unpack, special-case detect, exponent and mantissa alignment.
// Depends on ddr_pkg.
module ddr_prep import ddr_pkg::*; (
  input  logic [DataW-1:0] a,
  input  logic [DataW-1:0] b,
  output ddr_st_t          st
);
  logic [ManW-1:0] ma, mb;
  logic signed [ExpW-1:0] e;
  always_comb begin
    ma = {1'b1, a[51:0]};
    mb = {1'b1, b[51:0]};
    e = $signed({2'b0, a[62:52]}) - $signed({2'b0, b[62:52]}) + $signed(Rebias);
    st.sign = a[63] ^ b[63];
    st.zden = (b[62:0] == '0);
    st.znum = (a[62:0] == '0);
    st.den = mb;
    st.quo = '0;
    if (ma < mb) begin
      st.num = {ma, 1'b0};
      st.exp = e - 13'sd1;
    end else begin
      st.num = {1'b0, ma};
      st.exp = e;
    end
  end
endmodule

@@ design/ddr_step.sv @@
// One pipeline stage of restoring division: BitsSt quotient bits.
// Depends on ddr_pkg.
module ddr_step import ddr_pkg::*; (
  input  ddr_st_t di,
  output ddr_st_t dq
);
  logic [ManW:0] n;
  logic [QuotW-1:0] q;
  always_comb begin
    n = di.num;
    q = di.quo;
    for (int i = 0; i < BitsSt; i++) begin
      q = {q[QuotW-2:0], 1'b0};
      if (n >= {1'b0, di.den}) begin
        q[0] = 1'b1;
        n = n - {1'b0, di.den};
      end
      n = {n[ManW-1:0], 1'b0};
    end
    dq = di;
    dq.num = n;
    dq.quo = q;
  end
endmodule

@@ design/ddr_round.sv @@
// Rounding, denormalization and result packing.
// Depends on ddr_pkg.
module ddr_round import ddr_pkg::*; (
  input  ddr_st_t          st,
  output logic [DataW-1:0] q,
  output logic             ovf
);
  logic [QuotW:0] r;
  logic [DataW-1:0] tot;
  logic [12:0] sh;
  always_comb begin
    ovf = 1'b0;
    sh = 13'(-st.exp);
    r = '0;
    tot = '0;
    if (st.exp >= 0) begin
      r = ({1'b0, st.quo} + 55'd1) >> 1;
      tot = ({51'd0, st.exp[12:0]} << 52) + {9'd0, r};
    end else if (sh < 13'd54) begin
      r = ({1'b0, st.quo} + (55'd1 << sh[5:0])) >> (sh[5:0] + 6'd1);
      tot = {9'd0, r};
    end
    if (st.zden)
      q = st.sign ? '1 : 64'h7fff_ffff_ffff_ffff;
    else if (st.znum || (st.exp < 0 && sh >= 13'd54))
      q = {st.sign, 63'd0};
    else if (st.exp >= $signed({2'b0, ExpMax}) || tot[63:52] >= {1'b0, ExpMax}) begin
      q = {st.sign, ExpMax, 52'd0};
      ovf = 1'b1;
    end else
      q = {st.sign, tot[62:0]};
  end
endmodule

@@ design/double_divide_restoring_unit.sv @@
// Pipeline: prep stage, six division stages of nine quotient bits each, round
// stage. Throughput: one beat per cycle while the output is not stalled.
// Reset: rst synchronous active high clears all stage valid bits.
// Depends on ddr_pkg, ddr_if, ddr_prep, ddr_step, ddr_round.
module double_divide_restoring_unit import ddr_pkg::*; (
  input  logic clk,
  input  logic rst,
  ddr_if.sink   in_ch,
  ddr_if.source out_ch
);
  ddr_st_t st [0:NumSt];
  ddr_st_t nx [0:NumSt];
  logic    v  [0:NumSt];
  logic    ov;
  logic [DataW:0] ob;
  logic [DataW-1:0] rq;
  logic rovf;
  logic adv;

  assign adv = !ov || out_ch.ready;
  assign in_ch.ready = adv;

  ddr_prep u_prep(.a(in_ch.data[127:64]), .b(in_ch.data[63:0]), .st(nx[0]));
  for (genvar g = 1; g <= NumSt; g++) begin : g_st
    ddr_step u_step(.di(st[g-1]), .dq(nx[g]));
  end
  ddr_round u_round(.st(st[NumSt]), .q(rq), .ovf(rovf));

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= nx[0];
      for (int i = 1; i <= NumSt; i++) st[i] <= nx[i];
      ob <= {rq, rovf};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NumSt; i++) v[i] <= 1'b0;
      ov <= 1'b0;
    end else if (adv) begin
      v[0] <= in_ch.valid;
      for (int i = 1; i <= NumSt; i++) v[i] <= v[i-1];
      ov <= v[NumSt];
    end
  end

  assign out_ch.valid = ov;
  assign out_ch.data = ob;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    ov && !out_ch.ready |=> ov && $stable(ob)) else $error("output lost on stall");
  a_ovf_inf: assert property (@(posedge clk) disable iff (rst)
    ov && ob[0] |-> ob[63:53] == ExpMax && ob[52:1] == '0) else $error("bad overflow");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !ov |-> in_ch.ready) else $error("ready low while output empty");
endmodule
